@@ rtl/assert_macros.svh @@
// assertion helpers shared by the meter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on the rising clock, off while reset is asserted
`define RPAM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion %m failed");

// same-cycle implication
`define RPAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion %m failed");

`endif

@@ rtl/rpam_pkg.sv @@
// ----------------------------------------------------------------------------
// rpam_pkg
// Shared widths, constants and codes of the signal-strength meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpam_pkg;

  localparam int RSSI_W      = 9;
  localparam int LIMIT_W     = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_SAMPLES = 4095;

  // count holds 0..MAX_SAMPLES, sum needs the sample width on top of it
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W      = CNT_W + RSSI_W;
  localparam int DIVD_W     = SUM_W - 1;
  localparam int DIV_STEP_W = $clog2(DIVD_W);

  localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = -9'sd175;

  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_LIMIT = 1'b1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

endpackage

`default_nettype wire

@@ rtl/rpam_div.sv @@
// ----------------------------------------------------------------------------
// rpam_div
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rpam_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rpam_pkg::DIVD_W-1:0]  dividend_i,
  input  wire logic [rpam_pkg::CNT_W-1:0]   divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [rpam_pkg::DIVD_W-1:0]       quot_o
);
  import rpam_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      dsr_q, dsr_d;
  logic [DIVD_W-1:0]     quo_q, quo_d;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           ge;

  // dividend bits shift out of quo_q while quotient bits shift in
  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = DIV_STEP_W'(DIVD_W - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[DIVD_W-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  `RPAM_ASSERT_IMP(a_no_restart_busy, clk_i, rst_ni, start_i, !busy_q)
  `RPAM_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `RPAM_ASSERT_IMP(a_step_in_range, clk_i, rst_ni, busy_q, (step_q <= DIV_STEP_W'(DIVD_W - 1)))

endmodule

`default_nettype wire

@@ rtl/rssi_peak_average_meter_unit.sv @@
// ----------------------------------------------------------------------------
// rssi_peak_average_meter_unit
// Interval peak / average meter for signed signal-strength samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): req_type_i 0 carries a sample in
// rssi_sample_i, 1 closes the interval. Output channel (out_valid_o /
// out_stall_i) carries one report per interval end taken before the run is over.
// A sample gives no report and is taken back to back while in_stall_o is low.
// An interval end in peak mode, or in average mode with no samples, puts the
// report on the output register the cycle after it is accepted.
// An interval end in average mode with samples runs the serial divider, one
// quotient bit per cycle; the report is registered when the divider is done,
// and the input is stalled meanwhile.
// The user makes config writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) only while
// the block is idle (not enforced); a report limit write starts a new run.
// Reset leaves peak mode, endless run, empty interval, no pending report.
// While the receiver stalls, the report holds and samples are still taken,
// but the next interval end waits until the report is gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rssi_peak_average_meter_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rpam_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  wire logic [rpam_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 req_type_i,
  input  wire logic signed [rpam_pkg::RSSI_W-1:0]   rssi_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [rpam_pkg::RSSI_W-1:0]        rssi_report_o,
  output logic                                      empty_interval_o,
  output logic                                      run_done_o
);
  import rpam_pkg::*;

  state_e                     state_q, state_d;
  logic                       avg_mode_q, avg_mode_d;
  logic [LIMIT_W-1:0]         left_q, left_d;
  logic                       finished_q, finished_d;
  logic signed [RSSI_W-1:0]   peak_q, peak_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [RSSI_W-1:0]   report_q, report_d;
  logic                       empty_q, empty_d;
  logic                       done_q, done_d;
  logic                       neg_q, neg_d;
  logic                       pend_done_q, pend_done_d;

  logic                       in_acc;
  logic                       smp;
  logic                       tick;
  logic                       use_div;
  logic                       last;
  logic [SUM_W-1:0]           sum_abs;
  logic                       div_busy;
  logic                       div_done;
  logic [DIVD_W-1:0]          div_quot;
  logic [RSSI_W-1:0]          quot_lo;
  logic signed [RSSI_W-1:0]   mean;

  // an interval end waits for the previous report to leave
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && (req_type_i == REQ_TICK));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign smp        = in_acc && !finished_q && (req_type_i == REQ_SAMPLE);
  assign tick       = in_acc && !finished_q && (req_type_i == REQ_TICK);
  assign use_div    = tick && avg_mode_q && (count_q != '0);
  assign last       = (left_q == LIMIT_W'(1));

  assign sum_abs = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;

  rpam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (use_div),
    .dividend_i (sum_abs[DIVD_W-1:0]),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // quotient magnitude never exceeds 256, so the low bits carry it
  assign quot_lo = div_quot[RSSI_W-1:0];
  assign mean    = neg_q ? signed'(RSSI_W'(0) - quot_lo) : signed'(quot_lo);

  always_comb begin
    state_d     = state_q;
    avg_mode_d  = avg_mode_q;
    left_d      = left_q;
    finished_d  = finished_q;
    peak_d      = peak_q;
    sum_d       = sum_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    report_d    = report_q;
    empty_d     = empty_q;
    done_d      = done_q;
    neg_d       = neg_q;
    pend_done_d = pend_done_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (smp) begin
      if (avg_mode_q) begin
        if (count_q < CNT_W'(MAX_SAMPLES)) begin
          count_d = count_q + 1'b1;
          sum_d   = sum_q + SUM_W'(rssi_sample_i);
        end
      end else if (rssi_sample_i[RSSI_W-1] && (rssi_sample_i > peak_q)) begin
        peak_d = rssi_sample_i;
      end
    end

    if (tick) begin
      if (left_q != '0) begin
        left_d     = left_q - 1'b1;
        finished_d = last;
      end
      peak_d  = RSSI_FLOOR;
      sum_d   = '0;
      count_d = '0;
      if (use_div) begin
        state_d     = ST_DIV;
        neg_d       = sum_q[SUM_W-1];
        pend_done_d = (left_q != '0) && last;
      end else begin
        out_valid_d = 1'b1;
        report_d    = avg_mode_q ? RSSI_FLOOR : peak_q;
        empty_d     = avg_mode_q;
        done_d      = (left_q != '0) && last;
      end
    end

    if (div_done) begin
      state_d     = ST_IDLE;
      out_valid_d = 1'b1;
      report_d    = mean;
      empty_d     = 1'b0;
      done_d      = pend_done_q;
    end

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_AVERAGE_MODE: avg_mode_d = cfg_wdata_i[0];
        REG_REPORT_LIMIT: begin
          left_d     = cfg_wdata_i[LIMIT_W-1:0];
          finished_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      avg_mode_q  <= 1'b0;
      left_q      <= '0;
      finished_q  <= 1'b0;
      peak_q      <= RSSI_FLOOR;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      avg_mode_q  <= avg_mode_d;
      left_q      <= left_d;
      finished_q  <= finished_d;
      peak_q      <= peak_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    report_q    <= report_d;
    empty_q     <= empty_d;
    done_q      <= done_d;
    neg_q       <= neg_d;
    pend_done_q <= pend_done_d;
  end

  assign out_valid_o      = out_valid_q;
  assign rssi_report_o    = report_q;
  assign empty_interval_o = empty_q;
  assign run_done_o       = done_q;

  `RPAM_ASSERT_IMP(a_stall_in_div, clk_i, rst_ni, (state_q == ST_DIV), in_stall_o)
  `RPAM_ASSERT_IMP(a_done_only_in_div, clk_i, rst_ni, div_done, (state_q == ST_DIV))
  `RPAM_ASSERT_IMP(a_div_start_out_free, clk_i, rst_ni, use_div, (!out_valid_q && !div_busy))

endmodule

`default_nettype wire

@@ verif/rssi_peak_average_meter_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_peak_average_meter_unit_test
// Self-checking bench for the interval peak / average meter. A directed table
// covers floor, extremes, empty intervals, mode switches inside an interval
// and limited runs. Random phases follow, with random idling on both
// channels. Every accepted request goes through a local model of the meter,
// and each report is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rssi_peak_average_meter_unit_test;
  import rpam_pkg::*;

  localparam int RAND_ITEMS   = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 32;

  localparam logic signed [RSSI_W-1:0] SMP_LOW  = 9'h100;
  localparam logic signed [RSSI_W-1:0] SMP_HIGH = 9'h0ff;

  typedef struct packed {
    logic signed [RSSI_W-1:0] level;
    logic                     empty;
    logic                     done;
  } report_t;

  typedef enum {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic                     req;
    logic signed [RSSI_W-1:0] smp;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         data;
    report_t                  want;
  } dir_row_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_addr_i    = '0;
  logic [CFG_W-1:0]         cfg_wdata_i   = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     req_type_i    = 1'b0;
  logic signed [RSSI_W-1:0] rssi_sample_i = '0;
  logic                     out_stall_i   = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [RSSI_W-1:0] rssi_report_o;
  logic                     empty_interval_o;
  logic                     run_done_o;

  rssi_peak_average_meter_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .rssi_sample_i    (rssi_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rssi_report_o    (rssi_report_o),
    .empty_interval_o (empty_interval_o),
    .run_done_o       (run_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // meter state as the bench sees it
  logic                     avg_mode  = 1'b0;
  logic [LIMIT_W-1:0]       runs_left = '0;
  bit                       run_over  = 1'b0;
  logic signed [RSSI_W-1:0] peak      = RSSI_FLOOR;
  int                       acc_sum   = 0;
  int                       acc_count = 0;

  report_t pending_reports[$];
  int      fail_count = 0;
  int      items_done = 0;
  bit      tx_steady  = 1'b0;
  bit      rx_quiet   = 1'b0;
  bit      want_hold  = 1'b0;
  int      hold_left  = 0;

  function automatic bit meter_step(input logic req, input logic signed [RSSI_W-1:0] smp,
                                    output report_t r);
    int quot;
    r = '0;
    if (run_over) return 1'b0;
    if (req == REQ_SAMPLE) begin
      if (avg_mode) begin
        // counter saturates, later samples are dropped
        if (acc_count < MAX_SAMPLES) begin
          acc_count++;
          acc_sum += smp;
        end
      end else if (smp < 0 && smp > peak) begin
        peak = smp;
      end
      return 1'b0;
    end
    if (!avg_mode) begin
      r.level = peak;
    end else if (acc_count == 0) begin
      r.level = RSSI_FLOOR;
      r.empty = 1'b1;
    end else begin
      quot = acc_sum / acc_count;
      r.level = quot[RSSI_W-1:0];
    end
    if (runs_left != 0) begin
      runs_left--;
      if (runs_left == 0) begin
        r.done = 1'b1;
        run_over = 1'b1;
      end
    end
    peak = RSSI_FLOOR;
    acc_sum = 0;
    acc_count = 0;
    return 1'b1;
  endfunction

  function automatic logic signed [RSSI_W-1:0] rand_rssi();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return RSSI_W'($urandom);
    if (pick < 80) return -RSSI_W'($urandom_range(20, 175));
    if (pick < 90) return -RSSI_W'($urandom_range(170, 180));
    case ($urandom_range(0, 5))
      0: return SMP_LOW;
      1: return SMP_HIGH;
      2: return '0;
      3: return -9'sd1;
      4: return RSSI_FLOOR;
      default: return -9'sd174;
    endcase
  endfunction

  function automatic dir_row_t row_item(input logic req, input logic signed [RSSI_W-1:0] smp);
    dir_row_t row;
    row = '{ROW_ITEM, req, smp, '0, '0, '0};
    return row;
  endfunction

  function automatic dir_row_t row_tick(input logic signed [RSSI_W-1:0] level,
                                        input logic empty, input logic done);
    dir_row_t row;
    row = '{ROW_TYPED, REQ_TICK, SMP_HIGH, '0, '0, '0};
    row.want = '{level, empty, done};
    return row;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    dir_row_t row;
    row = '{ROW_CFG, REQ_SAMPLE, '0, idx, data, '0};
    return row;
  endfunction

  // offer one request, hold it until taken, then predict its report
  task automatic send(input logic req, input logic signed [RSSI_W-1:0] smp,
                      input bit typed, input report_t want);
    int gap;
    int pick;
    report_t got;
    gap = 0;
    pick = $urandom_range(0, 99);
    if (!tx_steady) begin
      if (pick >= 96) gap = $urandom_range(10, 40);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    rssi_sample_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    if (!run_over) items_done++;
    if (meter_step(req, smp, got)) pending_reports.push_back(typed ? want : got);
  endtask

  // stop offering, let every predicted report drain and the divider settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_AVERAGE_MODE) begin
      avg_mode = data[0];
    end else begin
      runs_left = data[LIMIT_W-1:0];
      run_over = 1'b0;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver: takes reports, checks them, stalls at random
  always @(posedge clk_i) begin : rx_side
    report_t want;
    int pick;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected report: level %0d empty %0b done %0b",
                   rssi_report_o, empty_interval_o, run_done_o);
      end else begin
        want = pending_reports.pop_front();
        if (rssi_report_o !== want.level || empty_interval_o !== want.empty ||
            run_done_o !== want.done) begin
          fail_count++;
          if (fail_count <= 10)
            $display("report mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     want.level, want.empty, want.done,
                     rssi_report_o, empty_interval_o, run_done_o);
        end
      end
    end
    if (want_hold) begin
      hold_left = HOLD_CYCLES;
      want_hold = 1'b0;
    end
    pick = $urandom_range(0, 99);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (rx_quiet || pick < 70) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      if (pick >= 97) hold_left = $urandom_range(10, 40);
      else if (pick >= 85) hold_left = $urandom_range(1, 3);
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    logic [CFG_W-1:0] lim;
    int phase;
    int n_int;
    int n_smp;
    int pick;
    int start_items;

    // peak mode, endless run
    dir_rows.push_back(row_tick(RSSI_FLOOR, 1'b0, 1'b0));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd1));
    dir_rows.push_back(row_tick(-9'sd1, 1'b0, 1'b0));
    // non-negative and below-floor samples never raise the peak
    dir_rows.push_back(row_item(REQ_SAMPLE, '0));
    dir_rows.push_back(row_item(REQ_SAMPLE, SMP_HIGH));
    dir_rows.push_back(row_item(REQ_SAMPLE, SMP_LOW));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd176));
    dir_rows.push_back(row_tick(RSSI_FLOOR, 1'b0, 1'b0));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd174));
    dir_rows.push_back(row_tick(-9'sd174, 1'b0, 1'b0));
    // average mode, empty interval first
    dir_rows.push_back(row_cfg(REG_AVERAGE_MODE, 16'h0001));
    dir_rows.push_back(row_tick(RSSI_FLOOR, 1'b1, 1'b0));
    dir_rows.push_back(row_item(REQ_SAMPLE, SMP_HIGH));
    dir_rows.push_back(row_item(REQ_SAMPLE, 9'sd254));
    dir_rows.push_back(row_item(REQ_TICK, '0));
    dir_rows.push_back(row_item(REQ_SAMPLE, SMP_LOW));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd1));
    dir_rows.push_back(row_item(REQ_TICK, SMP_LOW));
    // mode flips inside an open interval
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd10));
    dir_rows.push_back(row_cfg(REG_AVERAGE_MODE, 16'hfffe));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd50));
    dir_rows.push_back(row_tick(-9'sd50, 1'b0, 1'b0));
    // single-report run, later requests are ignored until a new limit restarts it
    dir_rows.push_back(row_cfg(REG_REPORT_LIMIT, 16'h0001));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd100));
    dir_rows.push_back(row_tick(-9'sd100, 1'b0, 1'b1));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd20));
    dir_rows.push_back(row_item(REQ_TICK, '0));
    dir_rows.push_back(row_cfg(REG_REPORT_LIMIT, 16'hffff));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd60));
    dir_rows.push_back(row_cfg(REG_AVERAGE_MODE, 16'h0001));
    dir_rows.push_back(row_item(REQ_SAMPLE, -9'sd20));
    dir_rows.push_back(row_item(REQ_TICK, '0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send(dir_rows[i].req, dir_rows[i].smp, dir_rows[i].kind == ROW_TYPED,
             dir_rows[i].want);
      end
    end

    start_items = items_done;
    phase = 0;
    while (items_done - start_items < RAND_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 4);
      tx_steady = (pick == 0);
      rx_quiet = (pick == 0);
      write_reg(REG_AVERAGE_MODE, {15'($urandom), 1'($urandom)});
      if (phase == 2) begin
        // long receiver hold-off while requests keep coming
        tx_steady = 1'b1;
        write_reg(REG_REPORT_LIMIT, 16'h0000);
        want_hold = 1'b1;
      end else if (run_over || $urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) lim = '0;
        else if (pick < 85) lim = CFG_W'($urandom_range(1, 8));
        else if (pick < 95) lim = '1;
        else lim = CFG_W'($urandom);
        write_reg(REG_REPORT_LIMIT, lim);
      end
      n_int = (phase == 2) ? 8 : $urandom_range(2, 10);
      for (int k = 0; k < n_int && !run_over; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) n_smp = 0;
        else if (pick < 85) n_smp = $urandom_range(1, 6);
        else n_smp = $urandom_range(7, 40);
        repeat (n_smp) send(REQ_SAMPLE, rand_rssi(), 1'b0, '0);
        send(REQ_TICK, RSSI_W'($urandom), 1'b0, '0);
      end
      // stray requests after the run ended, or an interval left open
      if (run_over)
        repeat ($urandom_range(1, 4)) send(1'($urandom), rand_rssi(), 1'b0, '0);
      else if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 5)) send(REQ_SAMPLE, rand_rssi(), 1'b0, '0);
      phase++;
    end

    wait_idle();
    if (fail_count == 0)
      $display("rssi_peak_average_meter_unit_test OK");
    else
      $display("rssi_peak_average_meter_unit_test NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("rssi_peak_average_meter_unit_test NOT OK");
    $finish;
  end

endmodule
